@@ sv/ibr_pkg.sv @@
`default_nettype none

package ibr_pkg;

    // Default lattice coordinate width and the fixed port widths.
    localparam int COORD_BITS_DEF = 16;
    localparam int IN_W           = 16;
    localparam int OUT_W          = 35;

    // Which weight is zero when a reduction applies.
    typedef enum logic [1:0] {
        ZERO_W0,
        ZERO_W1,
        ZERO_W2
    } zsel_t;

endpackage

`default_nettype wire

@@ sv/ibr_wedge.sv @@
`default_nettype none

module ibr_wedge
    import ibr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [IN_W-1:0]        pt_a,
    input  logic signed [IN_W-1:0]        pt_b,
    input  logic signed [IN_W-1:0]        c0_a,
    input  logic signed [IN_W-1:0]        c0_b,
    input  logic signed [IN_W-1:0]        c1_a,
    input  logic signed [IN_W-1:0]        c1_b,
    input  logic signed [IN_W-1:0]        c2_a,
    input  logic signed [IN_W-1:0]        c2_b,
    output logic                          out_valid,
    output logic signed [2*COORD_BITS+2:0] w0,
    output logic signed [2*COORD_BITS+2:0] w1,
    output logic signed [2*COORD_BITS+2:0] w2,
    output logic signed [2*COORD_BITS+2:0] den
);

    localparam int C = COORD_BITS;
    localparam int D = C + 1;
    localparam int P = 2 * D;
    localparam int W = P + 1;

    // Coordinates reinterpreted at the configured width.
    logic signed [C-1:0] pa, pb, a0, b0, a1, b1, a2, b2;

    assign pa = C'($unsigned(pt_a));
    assign pb = C'($unsigned(pt_b));
    assign a0 = C'($unsigned(c0_a));
    assign b0 = C'($unsigned(c0_b));
    assign a1 = C'($unsigned(c1_a));
    assign b1 = C'($unsigned(c1_b));
    assign a2 = C'($unsigned(c2_a));
    assign b2 = C'($unsigned(c2_b));

    // Stage one: coordinate differences.
    logic                v1_reg;
    logic signed [D-1:0] e0a_reg, e0b_reg, f0a_reg, f0b_reg;
    logic signed [D-1:0] d1a_reg, d1b_reg, d2a_reg, d2b_reg, dpa_reg, dpb_reg;

    // Stage two: the eight products.
    logic                v2_reg;
    logic signed [P-1:0] pd0_reg, pd1_reg, p00_reg, p01_reg;
    logic signed [P-1:0] p10_reg, p11_reg, p20_reg, p21_reg;

    // Stage three: the wedges.
    logic                v3_reg;
    logic signed [W-1:0] w0_reg, w1_reg, w2_reg, den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e0a_reg <= D'(a1) - D'(pa);
            e0b_reg <= D'(b1) - D'(pb);
            f0a_reg <= D'(a2) - D'(pa);
            f0b_reg <= D'(b2) - D'(pb);
            d1a_reg <= D'(a1) - D'(a0);
            d1b_reg <= D'(b1) - D'(b0);
            d2a_reg <= D'(a2) - D'(a0);
            d2b_reg <= D'(b2) - D'(b0);
            dpa_reg <= D'(pa) - D'(a0);
            dpb_reg <= D'(pb) - D'(b0);

            pd0_reg <= P'(d1a_reg) * P'(d2b_reg);
            pd1_reg <= P'(d1b_reg) * P'(d2a_reg);
            p00_reg <= P'(e0a_reg) * P'(f0b_reg);
            p01_reg <= P'(e0b_reg) * P'(f0a_reg);
            p10_reg <= P'(dpa_reg) * P'(d2b_reg);
            p11_reg <= P'(dpb_reg) * P'(d2a_reg);
            p20_reg <= P'(d1a_reg) * P'(dpb_reg);
            p21_reg <= P'(d1b_reg) * P'(dpa_reg);

            den_reg <= W'(pd0_reg) - W'(pd1_reg);
            w0_reg  <= W'(p00_reg) - W'(p01_reg);
            w1_reg  <= W'(p10_reg) - W'(p11_reg);
            w2_reg  <= W'(p20_reg) - W'(p21_reg);
        end
    end

    assign out_valid = v3_reg;
    assign w0        = w0_reg;
    assign w1        = w1_reg;
    assign w2        = w2_reg;
    assign den       = den_reg;

endmodule

`default_nettype wire

@@ sv/ibr_reduce.sv @@
`default_nettype none

module ibr_reduce
    import ibr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [2*COORD_BITS+2:0] w0,
    input  logic signed [2*COORD_BITS+2:0] w1,
    input  logic signed [2*COORD_BITS+2:0] w2,
    input  logic signed [2*COORD_BITS+2:0] den,
    output logic                           out_valid,
    output logic signed [2*COORD_BITS+2:0] r_w0,
    output logic signed [2*COORD_BITS+2:0] r_w1,
    output logic signed [2*COORD_BITS+2:0] r_w2,
    output logic signed [2*COORD_BITS+2:0] r_den
);

    localparam int W  = 2 * COORD_BITS + 3;
    localparam int KW = $clog2(W + 1);
    localparam int NG = 2 * W;

    typedef struct packed {
        logic signed [W-1:0] w0;
        logic signed [W-1:0] w1;
        logic signed [W-1:0] w2;
        logic signed [W-1:0] den;
        logic                red;
        zsel_t               zsel;
        logic                sx;
        logic                sy;
        logic [W-1:0]        mx;
        logic [W-1:0]        my;
    } side_t;

    typedef struct packed {
        side_t         s;
        logic [W-1:0]  a;
        logic [W-1:0]  b;
        logic [KW-1:0] k;
    } gcd_t;

    typedef struct packed {
        side_t        s;
        logic [W-1:0] g;
        logic [W-1:0] rx;
        logic [W-1:0] qx;
        logic [W-1:0] ry;
        logic [W-1:0] qy;
    } div_t;

    gcd_t gst_reg [NG+1];
    logic gv_reg  [NG+1];
    div_t dst_reg [W+1];
    logic dv_reg  [W+1];

    // Entry: find the zero weight and the two magnitudes to reduce.
    gcd_t                entry_next;
    logic                z0, z1, z2;
    logic signed [W-1:0] x, y;

    always_comb
    begin
        z0 = (w0 == '0);
        z1 = (w1 == '0);
        z2 = (w2 == '0);
        entry_next.s.w0  = w0;
        entry_next.s.w1  = w1;
        entry_next.s.w2  = w2;
        entry_next.s.den = den;
        entry_next.s.red = (z0 && !z1 && !z2) || (!z0 && z1 && !z2) || (!z0 && !z1 && z2);
        if (z0)
        begin
            entry_next.s.zsel = ZERO_W0;
            x = w1;
            y = w2;
        end
        else if (z1)
        begin
            entry_next.s.zsel = ZERO_W1;
            x = w0;
            y = w2;
        end
        else
        begin
            entry_next.s.zsel = ZERO_W2;
            x = w0;
            y = w1;
        end
        entry_next.s.sx = x[W-1];
        entry_next.s.sy = y[W-1];
        entry_next.s.mx = x[W-1] ? W'(-x) : W'(x);
        entry_next.s.my = y[W-1] ? W'(-y) : W'(y);
        entry_next.a    = entry_next.s.red ? entry_next.s.mx : W'(1);
        entry_next.b    = entry_next.s.red ? entry_next.s.my : W'(1);
        entry_next.k    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            gv_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gst_reg[0] <= entry_next;
        end
    end

    // Binary gcd: one step per stage; until a or b reaches zero, each step shortens a or b by a bit.
    for (genvar i = 0; i < NG; i++)
    begin : g_gcd
        gcd_t step_next;

        always_comb
        begin
            step_next = gst_reg[i];
            if (gst_reg[i].a == '0 || gst_reg[i].b == '0)
            begin
                step_next = gst_reg[i];
            end
            else if (!gst_reg[i].a[0] && !gst_reg[i].b[0])
            begin
                step_next.a = gst_reg[i].a >> 1;
                step_next.b = gst_reg[i].b >> 1;
                step_next.k = gst_reg[i].k + KW'(1);
            end
            else if (!gst_reg[i].a[0])
            begin
                step_next.a = gst_reg[i].a >> 1;
            end
            else if (!gst_reg[i].b[0])
            begin
                step_next.b = gst_reg[i].b >> 1;
            end
            else if (gst_reg[i].a >= gst_reg[i].b)
            begin
                step_next.a = (gst_reg[i].a - gst_reg[i].b) >> 1;
            end
            else
            begin
                step_next.b = (gst_reg[i].b - gst_reg[i].a) >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                gv_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                gv_reg[i+1] <= gv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                gst_reg[i+1] <= step_next;
            end
        end
    end

    // The gcd is the surviving odd part shifted back by the common power of two.
    div_t gfin_next;

    always_comb
    begin
        gfin_next.s  = gst_reg[NG].s;
        gfin_next.g  = W'((gst_reg[NG].a | gst_reg[NG].b) << gst_reg[NG].k);
        gfin_next.rx = '0;
        gfin_next.qx = gst_reg[NG].s.mx;
        gfin_next.ry = '0;
        gfin_next.qy = gst_reg[NG].s.my;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_reg[0] <= gv_reg[NG];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dst_reg[0] <= gfin_next;
        end
    end

    // Restoring division of both magnitudes by the gcd, one quotient bit per stage.
    for (genvar j = 0; j < W; j++)
    begin : g_div
        div_t       div_next;
        logic [W:0] tx, ty;

        always_comb
        begin
            div_next = dst_reg[j];
            tx = {dst_reg[j].rx, dst_reg[j].qx[W-1]};
            ty = {dst_reg[j].ry, dst_reg[j].qy[W-1]};
            if (tx >= {1'b0, dst_reg[j].g})
            begin
                div_next.rx = W'(tx - {1'b0, dst_reg[j].g});
                div_next.qx = {dst_reg[j].qx[W-2:0], 1'b1};
            end
            else
            begin
                div_next.rx = W'(tx);
                div_next.qx = {dst_reg[j].qx[W-2:0], 1'b0};
            end
            if (ty >= {1'b0, dst_reg[j].g})
            begin
                div_next.ry = W'(ty - {1'b0, dst_reg[j].g});
                div_next.qy = {dst_reg[j].qy[W-2:0], 1'b1};
            end
            else
            begin
                div_next.ry = W'(ty);
                div_next.qy = {dst_reg[j].qy[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[j+1] <= dv_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dst_reg[j+1] <= div_next;
            end
        end
    end

    // Restore signs; the reduced denominator is the sum of the two reduced weights.
    logic signed [W-1:0] vx, vy, vsum;

    always_comb
    begin
        vx    = dst_reg[W].s.sx ? -$signed(dst_reg[W].qx) : $signed(dst_reg[W].qx);
        vy    = dst_reg[W].s.sy ? -$signed(dst_reg[W].qy) : $signed(dst_reg[W].qy);
        vsum  = vx + vy;
        r_w0  = dst_reg[W].s.w0;
        r_w1  = dst_reg[W].s.w1;
        r_w2  = dst_reg[W].s.w2;
        r_den = dst_reg[W].s.den;
        if (dst_reg[W].s.red)
        begin
            r_den = vsum;
            case (dst_reg[W].s.zsel)
                ZERO_W0:
                begin
                    r_w0 = '0;
                    r_w1 = vx;
                    r_w2 = vy;
                end
                ZERO_W1:
                begin
                    r_w0 = vx;
                    r_w1 = '0;
                    r_w2 = vy;
                end
                default:
                begin
                    r_w0 = vx;
                    r_w1 = vy;
                    r_w2 = '0;
                end
            endcase
        end
    end

    assign out_valid = dv_reg[W];

endmodule

`default_nettype wire

@@ sv/integer_barycentric_reduced.sv @@
`default_nettype none

// Channel  Handshake             Payload
// input    in_valid / in_ready   pt_a pt_b c0_a c0_b c1_a c1_b c2_a c2_b (16 bits signed)
// output   out_valid / out_ready weight0 weight1 weight2 denominator (35 bits signed)
//
// One word can enter in every cycle in which the output register is empty or being taken.
// With W = 2*COORD_BITS + 3, the pipeline holds the binary gcd chain of 2*W stages
// and the restoring divider of W stages.
// Reset clears only the valid bits of the pipeline and of the output register.
// When the output word is held, the whole pipeline freezes, so nothing is lost or
// repeated; in_ready is high whenever the output register is empty or being taken.

module integer_barycentric_reduced
    import ibr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [IN_W-1:0]  pt_a,
    input  logic signed [IN_W-1:0]  pt_b,
    input  logic signed [IN_W-1:0]  c0_a,
    input  logic signed [IN_W-1:0]  c0_b,
    input  logic signed [IN_W-1:0]  c1_a,
    input  logic signed [IN_W-1:0]  c1_b,
    input  logic signed [IN_W-1:0]  c2_a,
    input  logic signed [IN_W-1:0]  c2_b,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] weight0,
    output logic signed [OUT_W-1:0] weight1,
    output logic signed [OUT_W-1:0] weight2,
    output logic signed [OUT_W-1:0] denominator
);

    localparam int W = 2 * COORD_BITS + 3;

    // Valid bit of the output register.
    logic out_valid_reg;

    // The pipeline moves whenever the output register can take a new word.
    logic en;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Front end: differences, products and the four wedges.
    logic                wv;
    logic signed [W-1:0] w0, w1, w2, den;

    ibr_wedge #(
        .COORD_BITS (COORD_BITS)
    ) u_wedge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .pt_a      (pt_a),
        .pt_b      (pt_b),
        .c0_a      (c0_a),
        .c0_b      (c0_b),
        .c1_a      (c1_a),
        .c1_b      (c1_b),
        .c2_a      (c2_a),
        .c2_b      (c2_b),
        .out_valid (wv),
        .w0        (w0),
        .w1        (w1),
        .w2        (w2),
        .den       (den)
    );

    // Back end: gcd of the two nonzero weights when exactly one weight is zero, and the exact division by it.
    logic                rv;
    logic signed [W-1:0] r_w0, r_w1, r_w2, r_den;

    ibr_reduce #(
        .COORD_BITS (COORD_BITS)
    ) u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (wv),
        .w0        (w0),
        .w1        (w1),
        .w2        (w2),
        .den       (den),
        .out_valid (rv),
        .r_w0      (r_w0),
        .r_w1      (r_w1),
        .r_w2      (r_w2),
        .r_den     (r_den)
    );

    // Output register, loaded only when a valid word arrives.
    logic signed [OUT_W-1:0] weight0_reg, weight1_reg, weight2_reg, denominator_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= rv;
        end
    end

    // A size cast of a signed value sign-extends or truncates to the port width.
    always_ff @(posedge clk)
    begin
        if (en && rv)
        begin
            weight0_reg     <= OUT_W'(r_w0);
            weight1_reg     <= OUT_W'(r_w1);
            weight2_reg     <= OUT_W'(r_w2);
            denominator_reg <= OUT_W'(r_den);
        end
    end

    assign out_valid   = out_valid_reg;
    assign weight0     = weight0_reg;
    assign weight1     = weight1_reg;
    assign weight2     = weight2_reg;
    assign denominator = denominator_reg;

endmodule

`default_nettype wire

@@ dv/integer_barycentric_reduced_tb.sv @@
`default_nettype none

module integer_barycentric_reduced_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ibr_pkg::*;

    // The pipeline is 3*W + 6 deep, with W = 2*COORD_BITS + 3.
    localparam int CB        = COORD_BITS_DEF;
    localparam int LATENCY   = 3 * (2 * CB + 3) + 6;
    localparam int MAX_CYCLE = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [IN_W-1:0] pt_a = '0, pt_b = '0, c0_a = '0, c0_b = '0;
    logic signed [IN_W-1:0] c1_a = '0, c1_b = '0, c2_a = '0, c2_b = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [OUT_W-1:0] weight0, weight1, weight2, denominator;

    // One expected output word: the three weights and the denominator.
    typedef struct packed {
        logic [OUT_W-1:0] w0;
        logic [OUT_W-1:0] w1;
        logic [OUT_W-1:0] w2;
        logic [OUT_W-1:0] den;
    } bary_t;

    bary_t pending_weights[$];
    int    errors = 0;
    int    cycle = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;

    integer_barycentric_reduced dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .pt_a(pt_a), .pt_b(pt_b), .c0_a(c0_a), .c0_b(c0_b),
        .c1_a(c1_a), .c1_b(c1_b), .c2_a(c2_a), .c2_b(c2_b),
        .out_valid(out_valid), .out_ready(out_ready),
        .weight0(weight0), .weight1(weight1), .weight2(weight2),
        .denominator(denominator)
    );

    always #1 clk = ~clk;

    // The cycle counter doubles as the watchdog for a hung pipeline.
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Coordinates are sign-extended from bit CB-1; higher bits are ignored.
    function automatic longint lattice_value(logic [IN_W-1:0] v);
        logic [CB-1:0] low;
        low = v[CB-1:0];
        return longint'($signed(low));
    endfunction

    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Computes the barycentric weights and applies the gcd reduction when
    // exactly one weight is zero.
    function automatic bary_t predict_weights(logic [IN_W-1:0] f[8]);
        longint pa, pb, a0, b0, a1, b1, a2, b2, den, w0, w1, w2;
        longint unsigned g;
        int zeros;
        bary_t r;
        pa = lattice_value(f[0]); pb = lattice_value(f[1]);
        a0 = lattice_value(f[2]); b0 = lattice_value(f[3]);
        a1 = lattice_value(f[4]); b1 = lattice_value(f[5]);
        a2 = lattice_value(f[6]); b2 = lattice_value(f[7]);
        den = (a1 - a0) * (b2 - b0) - (b1 - b0) * (a2 - a0);
        w0 = (a1 - pa) * (b2 - pb) - (b1 - pb) * (a2 - pa);
        w1 = (pa - a0) * (b2 - b0) - (pb - b0) * (a2 - a0);
        w2 = (a1 - a0) * (pb - b0) - (b1 - b0) * (pa - a0);
        zeros = int'(w0 == 0) + int'(w1 == 0) + int'(w2 == 0);
        if (zeros == 1)
        begin
            if (w0 == 0)
                g = gcd_of(magnitude(w1), magnitude(w2));
            else if (w1 == 0)
                g = gcd_of(magnitude(w0), magnitude(w2));
            else
                g = gcd_of(magnitude(w0), magnitude(w1));
            if (g > 1)
            begin
                w0 = w0 / longint'(g);
                w1 = w1 / longint'(g);
                w2 = w2 / longint'(g);
                den = den / longint'(g);
            end
        end
        r.w0 = w0[OUT_W-1:0];
        r.w1 = w1[OUT_W-1:0];
        r.w2 = w2[OUT_W-1:0];
        r.den = den[OUT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [OUT_W-1:0] got,
                                   logic [OUT_W-1:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle, field, got, want);
        errors++;
    endtask

    // The receiver stalls at random; each accepted word is checked against
    // the oldest prediction.
    always @(posedge clk)
    begin
        bary_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_weights.size() == 0)
                begin
                    $display("unexpected output word at cycle %0d", cycle);
                    errors++;
                end
                else
                begin
                    want = pending_weights.pop_front();
                    if (weight0 !== want.w0) report_mismatch("weight0", weight0, want.w0);
                    if (weight1 !== want.w1) report_mismatch("weight1", weight1, want.w1);
                    if (weight2 !== want.w2) report_mismatch("weight2", weight2, want.w2);
                    if (denominator !== want.den)
                        report_mismatch("denominator", denominator, want.den);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Sends one word, with a random gap before it, and records its prediction
    // at the edge where it is accepted.
    task automatic send_word(logic [IN_W-1:0] f[8]);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pt_a <= f[0]; pt_b <= f[1]; c0_a <= f[2]; c0_b <= f[3];
        c1_a <= f[4]; c1_b <= f[5]; c2_a <= f[6]; c2_b <= f[7];
        do
            @(posedge clk);
        while (!in_ready);
        pending_weights.push_back(predict_weights(f));
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_weights.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [IN_W-1:0] random_coord();
        case ($urandom_range(5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return IN_W'($urandom_range(15)) - 16'd8;
            default: return IN_W'($urandom);
        endcase
    endfunction

    // Extremes of every coordinate, a degenerate triangle, a point on an edge
    // (one zero weight, reducible) and a point on a corner (two zero weights).
    task automatic test_directed();
        logic [IN_W-1:0] f[8];
        f = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
        send_word(f);
        f = '{16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff};
        send_word(f);
        f = '{16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff};
        send_word(f);
        f = '{16'hffff, 16'hffff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h0000, 16'h0001};
        send_word(f);
        f = '{16'd2, 16'd2, 16'd0, 16'd0, 16'd4, 16'd4, 16'd8, 16'd8};
        send_word(f);
        f = '{16'd6, 16'd0, 16'd0, 16'd0, 16'd12, 16'd0, 16'd0, 16'd12};
        send_word(f);
        f = '{16'd0, 16'd6, 16'd0, 16'd0, 16'd12, 16'd0, 16'd0, 16'd12};
        send_word(f);
        f = '{16'd3, 16'd3, 16'd0, 16'd0, 16'd12, 16'd0, 16'd0, 16'd12};
        send_word(f);
        f = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd12, 16'd0, 16'd0, 16'd12};
        send_word(f);
        f = '{16'd1, 16'd1, 16'd0, 16'd0, 16'd5, 16'd0, 16'd0, 16'd5};
        send_word(f);
        f = '{16'h8000, 16'h0000, 16'h8000, 16'h8000, 16'h7fff, 16'h0000, 16'h8000, 16'h7fff};
        send_word(f);
        f = '{16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'h1234, 16'hedcb, 16'h0f0f, 16'hf0f0};
        send_word(f);
    endtask

    // Random words, most of them with the point placed on the line through two
    // corners so that the gcd reduction is exercised.
    task automatic test_random(int count);
        logic [IN_W-1:0] f[8];
        int k, m;
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 8; i++)
                f[i] = random_coord();
            if ($urandom_range(99) < 60)
            begin
                k = $urandom_range(2);
                m = $urandom_range(8) + 1;
                // Point = corner j + t*(corner l - corner j) / m with t a multiple of m.
                f[2] = IN_W'($urandom_range(2000)) - 16'd1000;
                f[3] = IN_W'($urandom_range(2000)) - 16'd1000;
                f[4] = f[2] + IN_W'(m * $urandom_range(100));
                f[5] = f[3] + IN_W'(m * ($urandom_range(100) - 50));
                f[6] = f[2] + IN_W'(m * ($urandom_range(100) - 50));
                f[7] = f[3] + IN_W'(m * $urandom_range(100));
                m = $urandom_range(3);
                case (k)
                    0:
                    begin
                        f[0] = f[2] + IN_W'(m) * (f[4] - f[2]);
                        f[1] = f[3] + IN_W'(m) * (f[5] - f[3]);
                    end
                    1:
                    begin
                        f[0] = f[2] + IN_W'(m) * (f[6] - f[2]);
                        f[1] = f[3] + IN_W'(m) * (f[7] - f[3]);
                    end
                    default:
                    begin
                        f[0] = f[4] + IN_W'(m) * (f[6] - f[4]);
                        f[1] = f[5] + IN_W'(m) * (f[7] - f[5]);
                    end
                endcase
            end
            send_word(f);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 35;
        recv_idle_pct = 47;
        test_directed();
        test_random(450);
        // The sender holds off until the pipeline is empty.
        drain_pipeline();
        send_idle_pct = 47;
        recv_idle_pct = 35;
        test_random(450);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(500);

        drain_pipeline();
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && pending_weights.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
